[rtl/core/adagrad_pkg.sv]
// ----------------------------------------------------------------------------
// AdaGrad update package
// Shared widths, types, configuration codes and arithmetic step functions.
// ----------------------------------------------------------------------------
package adagrad_pkg;

    localparam int IDX_W   = 12;
    localparam int DATA_W  = 32;
    localparam int STAB_W  = 16;
    localparam int ACC_W   = 64;
    localparam int ROOT_W  = ACC_W / 2;
    localparam int REM_W   = ROOT_W + 4;
    localparam int DEN_W   = ROOT_W + 1;
    localparam int QUO_W   = 34;
    localparam int RES_W   = 36;
    localparam int SQRT_STAGES = ROOT_W / 2;
    localparam int DIV_STAGES  = QUO_W / 2;

    localparam logic [QUO_W-1:0] STEP_LIMIT = QUO_W'(1) << 33;

    typedef enum logic [0:0] {
        CFG_LEARNING_RATE = 1'b0,
        CFG_STABILIZER    = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] param;
        logic                     gneg;
        logic                     sat;
    } side_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_acc_t;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } div_acc_t;

    // One digit of the restoring square root: two radicand bits per step.
    function automatic sqrt_acc_t sqrt_step(sqrt_acc_t a, logic [1:0] pair);
        sqrt_acc_t        r;
        logic [REM_W-1:0] sh;
        logic [REM_W-1:0] trial;
        sh    = {a.rem[REM_W-3:0], pair};
        trial = REM_W'({a.root, 2'b01});
        if (sh >= trial)
        begin
            r.rem  = sh - trial;
            r.root = {a.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = sh;
            r.root = {a.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // One quotient bit of the restoring division.
    function automatic div_acc_t div_step(div_acc_t a, logic [DEN_W-1:0] den, logic nb);
        div_acc_t       r;
        logic [DEN_W:0] sh;
        logic [DEN_W:0] diff;
        sh   = {a.rem, nb};
        diff = sh - {1'b0, den};
        if (sh >= {1'b0, den})
        begin
            r.rem = diff[DEN_W-1:0];
            r.quo = {a.quo[QUO_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = sh[DEN_W-1:0];
            r.quo = {a.quo[QUO_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

[rtl/core/adagrad_in_if.sv]
// ----------------------------------------------------------------------------
// AdaGrad update input channel
// Valid/ready channel that carries one parameter update request.
// ----------------------------------------------------------------------------
interface adagrad_in_if;
    import adagrad_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         element_index;
    logic signed [DATA_W-1:0] gradient;
    logic signed [DATA_W-1:0] param_value;
    logic                     restart;

    modport source (output valid, output element_index, output gradient,
                    output param_value, output restart, input ready);
    modport sink (input valid, input element_index, input gradient,
                  input param_value, input restart, output ready);
endinterface

[rtl/core/adagrad_out_if.sv]
// ----------------------------------------------------------------------------
// AdaGrad update output channel
// Valid/ready channel that carries one updated parameter.
// ----------------------------------------------------------------------------
interface adagrad_out_if;
    import adagrad_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] new_param;
    logic                     saturated;

    modport source (output valid, output new_param, output saturated, input ready);
    modport sink (input valid, input new_param, input saturated, output ready);
endinterface

[rtl/core/adagrad_accum.sv]
// ----------------------------------------------------------------------------
// AdaGrad accumulator stage
// Accumulator memory with clearing pass, read-modify-write with forwarding,
// gradient square and learning rate product.
// ----------------------------------------------------------------------------
module adagrad_accum #(
    parameter int NUM_ELEMENTS = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 adv,
    input  logic                                 accept,
    input  logic [adagrad_pkg::IDX_W-1:0]        element_index,
    input  logic signed [adagrad_pkg::DATA_W-1:0] gradient,
    input  logic signed [adagrad_pkg::DATA_W-1:0] param_value,
    input  logic                                 restart,
    input  logic [adagrad_pkg::DATA_W-1:0]       learning_rate,
    output logic                                 busy,
    output logic                                 out_valid,
    output logic [adagrad_pkg::ACC_W-1:0]        out_h,
    output logic [adagrad_pkg::ACC_W-1:0]        out_num,
    output adagrad_pkg::side_t                   out_side
);
    import adagrad_pkg::*;

    localparam int AW = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;

    logic [ACC_W-1:0] mem [NUM_ELEMENTS];

    logic              clr_busy_reg;
    logic [AW-1:0]     clr_addr_reg;

    logic              s1_valid_reg;
    logic [AW-1:0]     s1_addr_reg;
    logic              s1_inr_reg;
    logic              s1_restart_reg;
    logic [DATA_W-1:0] s1_gmag_reg;
    logic [ACC_W-1:0]  s1_sq_reg;
    side_t             s1_side_reg;
    logic [ACC_W-1:0]  rd_data_reg;

    logic              fwd_valid_reg;
    logic [AW-1:0]     fwd_addr_reg;
    logic [ACC_W-1:0]  fwd_data_reg;

    logic              s2_valid_reg;
    logic [ACC_W-1:0]  s2_h_reg;
    logic [ACC_W-1:0]  s2_num_reg;
    side_t             s2_side_reg;

    logic              in_gneg;
    logic [DATA_W-1:0] in_gmag;
    logic [ACC_W-1:0]  in_sq;
    logic              in_range;
    logic [AW-1:0]     in_addr;

    logic [ACC_W-1:0]  base;
    logic [ACC_W:0]    sum;
    logic [ACC_W-1:0]  h_next;
    logic [ACC_W-1:0]  num_next;
    side_t             side_next;
    logic              wr_item;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [ACC_W-1:0]  mem_wdata;

    assign in_gneg  = gradient[DATA_W-1];
    assign in_gmag  = in_gneg ? (DATA_W'(0) - gradient) : gradient;
    assign in_sq    = in_gmag * in_gmag;
    assign in_range = (32'(element_index) < 32'(NUM_ELEMENTS));
    assign in_addr  = AW'(element_index);

    always_comb
    begin
        if (s1_restart_reg || !s1_inr_reg)
        begin
            base = '0;
        end
        else if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg))
        begin
            base = fwd_data_reg;
        end
        else
        begin
            base = rd_data_reg;
        end
        sum       = {1'b0, base} + {1'b0, s1_sq_reg};
        h_next    = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
        num_next  = learning_rate * s1_gmag_reg;
        side_next = s1_side_reg;
        side_next.sat = sum[ACC_W];
    end

    assign wr_item   = adv && s1_valid_reg && s1_inr_reg;
    assign mem_we    = clr_busy_reg || wr_item;
    assign mem_waddr = clr_busy_reg ? clr_addr_reg : s1_addr_reg;
    assign mem_wdata = clr_busy_reg ? '0 : h_next;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (accept)
        begin
            rd_data_reg <= mem[in_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            fwd_valid_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(NUM_ELEMENTS - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (wr_item)
            begin
                fwd_valid_reg <= 1'b1;
            end
            if (adv)
            begin
                s1_valid_reg <= accept;
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_item)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= h_next;
        end
        if (adv)
        begin
            s1_addr_reg       <= in_addr;
            s1_inr_reg        <= in_range;
            s1_restart_reg    <= restart;
            s1_gmag_reg       <= in_gmag;
            s1_sq_reg         <= in_sq;
            s1_side_reg.param <= param_value;
            s1_side_reg.gneg  <= in_gneg;
            s1_side_reg.sat   <= 1'b0;
            s2_h_reg          <= h_next;
            s2_num_reg        <= num_next;
            s2_side_reg       <= side_next;
        end
    end

    assign busy      = clr_busy_reg;
    assign out_valid = s2_valid_reg;
    assign out_h     = s2_h_reg;
    assign out_num   = s2_num_reg;
    assign out_side  = s2_side_reg;

endmodule

[rtl/core/adagrad_isqrt.sv]
// ----------------------------------------------------------------------------
// AdaGrad square root pipeline
// Integer square root of the accumulator, two root bits per stage.
// ----------------------------------------------------------------------------
module adagrad_isqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  logic                            in_valid,
    input  logic [adagrad_pkg::ACC_W-1:0]   in_h,
    input  logic [adagrad_pkg::ACC_W-1:0]   in_num,
    input  adagrad_pkg::side_t              in_side,
    output logic                            out_valid,
    output logic [adagrad_pkg::ROOT_W-1:0]  out_root,
    output logic [adagrad_pkg::ACC_W-1:0]   out_num,
    output adagrad_pkg::side_t              out_side
);
    import adagrad_pkg::*;

    logic             valid_reg [SQRT_STAGES];
    logic [ACC_W-1:0] h_reg     [SQRT_STAGES];
    logic [ACC_W-1:0] num_reg   [SQRT_STAGES];
    side_t            side_reg  [SQRT_STAGES];
    sqrt_acc_t        acc_reg   [SQRT_STAGES];

    genvar s;
    for (s = 0; s < SQRT_STAGES; s++)
    begin : g_stage
        logic             prev_valid;
        logic [ACC_W-1:0] prev_h;
        logic [ACC_W-1:0] prev_num;
        side_t            prev_side;
        sqrt_acc_t        prev_acc;
        sqrt_acc_t        mid_acc;
        sqrt_acc_t        next_acc;

        if (s == 0)
        begin : g_first
            assign prev_valid = in_valid;
            assign prev_h     = in_h;
            assign prev_num   = in_num;
            assign prev_side  = in_side;
            assign prev_acc   = '0;
        end
        else
        begin : g_rest
            assign prev_valid = valid_reg[s-1];
            assign prev_h     = h_reg[s-1];
            assign prev_num   = num_reg[s-1];
            assign prev_side  = side_reg[s-1];
            assign prev_acc   = acc_reg[s-1];
        end

        assign mid_acc  = sqrt_step(prev_acc, prev_h[ACC_W-1-4*s -: 2]);
        assign next_acc = sqrt_step(mid_acc, prev_h[ACC_W-3-4*s -: 2]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[s] <= prev_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                h_reg[s]    <= prev_h;
                num_reg[s]  <= prev_num;
                side_reg[s] <= prev_side;
                acc_reg[s]  <= next_acc;
            end
        end
    end

    assign out_valid = valid_reg[SQRT_STAGES-1];
    assign out_root  = acc_reg[SQRT_STAGES-1].root;
    assign out_num   = num_reg[SQRT_STAGES-1];
    assign out_side  = side_reg[SQRT_STAGES-1];

endmodule

[rtl/core/adagrad_div.sv]
// ----------------------------------------------------------------------------
// AdaGrad division pipeline
// Forms the denominator, detects quotient overflow and divides two quotient
// bits per stage.
// ----------------------------------------------------------------------------
module adagrad_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  logic                            in_valid,
    input  logic [adagrad_pkg::ROOT_W-1:0]  in_root,
    input  logic [adagrad_pkg::ACC_W-1:0]   in_num,
    input  adagrad_pkg::side_t              in_side,
    input  logic [adagrad_pkg::STAB_W-1:0]  stabilizer,
    output logic                            out_valid,
    output logic [adagrad_pkg::QUO_W-1:0]   out_quo,
    output logic                            out_zero,
    output logic                            out_ovf,
    output adagrad_pkg::side_t              out_side
);
    import adagrad_pkg::*;

    logic             f_valid_reg;
    logic [DEN_W-1:0] f_den_reg;
    logic             f_zero_reg;
    logic             f_ovf_reg;
    logic [DEN_W-1:0] f_rem_reg;
    logic [QUO_W-1:0] f_lo_reg;
    side_t            f_side_reg;

    logic [DEN_W-1:0] den_next;
    logic [DEN_W-1:0] hi_next;

    assign den_next = DEN_W'(in_root) + DEN_W'(stabilizer);
    assign hi_next  = DEN_W'(in_num[ACC_W-1:QUO_W]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_den_reg  <= den_next;
            f_zero_reg <= (den_next == '0);
            f_ovf_reg  <= (hi_next >= den_next);
            f_rem_reg  <= hi_next;
            f_lo_reg   <= in_num[QUO_W-1:0];
            f_side_reg <= in_side;
        end
    end

    logic             valid_reg [DIV_STAGES];
    logic [DEN_W-1:0] den_reg   [DIV_STAGES];
    logic             zero_reg  [DIV_STAGES];
    logic             ovf_reg   [DIV_STAGES];
    logic [QUO_W-1:0] lo_reg    [DIV_STAGES];
    side_t            side_reg  [DIV_STAGES];
    div_acc_t         acc_reg   [DIV_STAGES];

    genvar s;
    for (s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        logic             prev_valid;
        logic [DEN_W-1:0] prev_den;
        logic             prev_zero;
        logic             prev_ovf;
        logic [QUO_W-1:0] prev_lo;
        side_t            prev_side;
        div_acc_t         prev_acc;
        div_acc_t         mid_acc;
        div_acc_t         next_acc;

        if (s == 0)
        begin : g_first
            assign prev_valid   = f_valid_reg;
            assign prev_den     = f_den_reg;
            assign prev_zero    = f_zero_reg;
            assign prev_ovf     = f_ovf_reg;
            assign prev_lo      = f_lo_reg;
            assign prev_side    = f_side_reg;
            assign prev_acc.rem = f_rem_reg;
            assign prev_acc.quo = '0;
        end
        else
        begin : g_rest
            assign prev_valid = valid_reg[s-1];
            assign prev_den   = den_reg[s-1];
            assign prev_zero  = zero_reg[s-1];
            assign prev_ovf   = ovf_reg[s-1];
            assign prev_lo    = lo_reg[s-1];
            assign prev_side  = side_reg[s-1];
            assign prev_acc   = acc_reg[s-1];
        end

        assign mid_acc  = div_step(prev_acc, prev_den, prev_lo[QUO_W-1-2*s]);
        assign next_acc = div_step(mid_acc, prev_den, prev_lo[QUO_W-2-2*s]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[s] <= prev_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                den_reg[s]  <= prev_den;
                zero_reg[s] <= prev_zero;
                ovf_reg[s]  <= prev_ovf;
                lo_reg[s]   <= prev_lo;
                side_reg[s] <= prev_side;
                acc_reg[s]  <= next_acc;
            end
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_quo   = acc_reg[DIV_STAGES-1].quo;
    assign out_zero  = zero_reg[DIV_STAGES-1];
    assign out_ovf   = ovf_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];

endmodule

[rtl/core/adagrad_parameter_update_unit.sv]
// ----------------------------------------------------------------------------
// AdaGrad parameter update unit
// Streams one parameter update per cycle while upd.ready is high: accumulates
// the squared gradient per element and returns
// param - lr * g / (sqrt(h) + stabilizer).
// Usage: requests arrive on the upd channel and results leave on the res
// channel; both are valid/ready channels and a transaction completes when
// valid and ready are high at a rising clock edge. Each request yields exactly
// one result, in order. The learning rate and stabilizer are written through
// cfg_we, cfg_index and cfg_wdata while no transaction is in flight.
// A new request is taken every cycle while upd.ready is high. Each request
// passes through the accumulator read-modify-write, sixteen square root
// stages, one denominator stage, seventeen division stages and the output
// register. Back-to-back requests to the same element are forwarded around
// the accumulator memory, so they also run at one per cycle.
// After reset the accumulator memory is cleared one entry per cycle, during
// which upd.ready stays low; configuration writes are still taken. When the
// receiver holds res.ready low while res.valid is high, the whole pipeline
// stalls in place and upd.ready drops until the output register drains.
// ----------------------------------------------------------------------------
module adagrad_parameter_update_unit #(
    parameter int NUM_ELEMENTS = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  adagrad_pkg::cfg_index_t           cfg_index,
    input  logic [adagrad_pkg::DATA_W-1:0]    cfg_wdata,
    adagrad_in_if.sink                        upd,
    adagrad_out_if.source                     res
);
    import adagrad_pkg::*;

    logic [DATA_W-1:0] lr_reg;
    logic [STAB_W-1:0] stab_reg;

    logic              adv;
    logic              accept;
    logic              busy;

    logic              acc_valid;
    logic [ACC_W-1:0]  acc_h;
    logic [ACC_W-1:0]  acc_num;
    side_t             acc_side;

    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    logic [ACC_W-1:0]  sq_num;
    side_t             sq_side;

    logic              dv_valid;
    logic [QUO_W-1:0]  dv_quo;
    logic              dv_zero;
    logic              dv_ovf;
    side_t             dv_side;

    logic [QUO_W-1:0]         step_mag;
    logic signed [RES_W-1:0]  p_ext;
    logic signed [RES_W-1:0]  step_ext;
    logic signed [RES_W-1:0]  r_wide;
    logic                     over_hi;
    logic                     over_lo;
    logic signed [DATA_W-1:0] new_param_next;
    logic                     saturated_next;

    logic                     res_valid_reg;
    logic signed [DATA_W-1:0] new_param_reg;
    logic                     saturated_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg   <= DATA_W'(655);
            stab_reg <= STAB_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LEARNING_RATE: lr_reg   <= cfg_wdata;
                CFG_STABILIZER:    stab_reg <= cfg_wdata[STAB_W-1:0];
                default:           lr_reg   <= lr_reg;
            endcase
        end
    end

    assign adv       = !res_valid_reg || res.ready;
    assign upd.ready = adv && !busy;
    assign accept    = upd.valid && upd.ready;

    adagrad_accum #(
        .NUM_ELEMENTS (NUM_ELEMENTS)
    ) u_accum (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .accept        (accept),
        .element_index (upd.element_index),
        .gradient      (upd.gradient),
        .param_value   (upd.param_value),
        .restart       (upd.restart),
        .learning_rate (lr_reg),
        .busy          (busy),
        .out_valid     (acc_valid),
        .out_h         (acc_h),
        .out_num       (acc_num),
        .out_side      (acc_side)
    );

    adagrad_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (acc_valid),
        .in_h      (acc_h),
        .in_num    (acc_num),
        .in_side   (acc_side),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_num   (sq_num),
        .out_side  (sq_side)
    );

    adagrad_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (sq_valid),
        .in_root    (sq_root),
        .in_num     (sq_num),
        .in_side    (sq_side),
        .stabilizer (stab_reg),
        .out_valid  (dv_valid),
        .out_quo    (dv_quo),
        .out_zero   (dv_zero),
        .out_ovf    (dv_ovf),
        .out_side   (dv_side)
    );

    always_comb
    begin
        if (dv_zero)
        begin
            step_mag = '0;
        end
        else if (dv_ovf || (dv_quo > STEP_LIMIT))
        begin
            step_mag = STEP_LIMIT;
        end
        else
        begin
            step_mag = dv_quo;
        end
        p_ext    = RES_W'(dv_side.param);
        step_ext = signed'(RES_W'(step_mag));
        r_wide   = dv_side.gneg ? (p_ext + step_ext) : (p_ext - step_ext);
        over_hi  = !r_wide[RES_W-1] && (r_wide[RES_W-2:DATA_W-1] != '0);
        over_lo  = r_wide[RES_W-1] && (r_wide[RES_W-2:DATA_W-1] != '1);
        if (over_hi)
        begin
            new_param_next = {1'b0, {(DATA_W-1){1'b1}}};
        end
        else if (over_lo)
        begin
            new_param_next = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            new_param_next = r_wide[DATA_W-1:0];
        end
        saturated_next = dv_side.sat || over_hi || over_lo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            new_param_reg <= new_param_next;
            saturated_reg <= saturated_next;
        end
    end

    assign res.valid     = res_valid_reg;
    assign res.new_param = new_param_reg;
    assign res.saturated = saturated_reg;

endmodule

[dv/adagrad_update_checker.sv]
// ----------------------------------------------------------------------------
// AdaGrad update checker
// Watches the configuration port and both channels, keeps its own copy of the
// accumulators and settings, predicts each updated parameter and compares it
// with the result transaction that comes out in order.
// ----------------------------------------------------------------------------
module adagrad_update_checker
    import adagrad_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  cfg_index_t          cfg_index,
    input  logic [DATA_W-1:0]   cfg_wdata,
    adagrad_in_if               upd,
    adagrad_out_if              res,
    output int                  errors,
    output int                  pending
);

    typedef struct {
        logic signed [DATA_W-1:0] new_param;
        logic                     saturated;
    } update_result_t;

    logic [ACC_W-1:0]  sq_sums [4096];
    logic [DATA_W-1:0] rate;
    logic [STAB_W-1:0] stab;
    update_result_t    expected_updates [$];

    function automatic logic [63:0] floor_root(logic [63:0] x);
        logic [63:0] root;
        logic [63:0] trial;
        root = 0;
        for (int i = 31; i >= 0; i--)
        begin
            trial = root | (64'd1 << i);
            if (trial * trial <= x)
                root = trial;
        end
        return root;
    endfunction

    function automatic update_result_t compute_update(logic [IDX_W-1:0] idx,
                                                      logic [DATA_W-1:0] g,
                                                      logic [DATA_W-1:0] p,
                                                      logic restart);
        update_result_t    r;
        logic              neg;
        logic [DATA_W-1:0] gmag32;
        logic [63:0]       gmag;
        logic [63:0]       sq;
        logic [63:0]       h;
        logic [63:0]       denom;
        logic [63:0]       step;
        longint            value;
        neg    = g[DATA_W-1];
        gmag32 = neg ? ((~g) + 32'd1) : g;
        gmag   = 64'(gmag32);
        sq     = gmag * gmag;
        h      = restart ? 64'd0 : sq_sums[idx];
        r.saturated = 1'b0;
        if (h > ~sq)
        begin
            h = '1;
            r.saturated = 1'b1;
        end
        else
            h = h + sq;
        sq_sums[idx] = h;
        denom = floor_root(h) + 64'(stab);
        if (denom == 0)
            step = 0;
        else
        begin
            step = (64'(rate) * gmag) / denom;
            if (step > (64'd1 << 33))
                step = 64'd1 << 33;
        end
        value = longint'($signed(p));
        value = neg ? value + longint'(step) : value - longint'(step);
        if (value > 64'sd2147483647)
        begin
            value = 64'sd2147483647;
            r.saturated = 1'b1;
        end
        else if (value < -64'sd2147483648)
        begin
            value = -64'sd2147483648;
            r.saturated = 1'b1;
        end
        r.new_param = value[31:0];
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        update_result_t want;
        if (!rst_n)
        begin
            foreach (sq_sums[i])
                sq_sums[i] = '0;
            rate = 32'd655;
            stab = 16'd1;
            expected_updates.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_LEARNING_RATE)
                    rate = cfg_wdata;
                else if (cfg_index == CFG_STABILIZER)
                    stab = cfg_wdata[STAB_W-1:0];
            end
            if (upd.valid && upd.ready)
                expected_updates.push_back(compute_update(upd.element_index, upd.gradient,
                                                          upd.param_value, upd.restart));
            if (res.valid && res.ready)
            begin
                if (expected_updates.size() == 0)
                    report("unexpected result", res.new_param, 32'd0);
                else
                begin
                    want = expected_updates.pop_front();
                    if (res.new_param !== want.new_param)
                        report("new_param", res.new_param, want.new_param);
                    if (res.saturated !== want.saturated)
                        report("saturated", 32'(res.saturated), 32'(want.saturated));
                end
            end
            pending = expected_updates.size();
        end
    end

endmodule

[dv/tb_adagrad_parameter_update_unit.sv]
// ----------------------------------------------------------------------------
// AdaGrad parameter update unit testbench
// Writes several learning rate and stabilizer settings, sends directed and
// random update transactions in bursts while the result side stalls, and
// takes the verdict from the checker that runs beside the block.
// ----------------------------------------------------------------------------
module tb_adagrad_parameter_update_unit;
    import adagrad_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    cfg_index_t        cfg_index;
    logic [DATA_W-1:0] cfg_wdata;
    int                errors;
    int                pending;
    logic              long_hold_go;

    adagrad_in_if  upd ();
    adagrad_out_if res ();

    adagrad_parameter_update_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .upd       (upd.sink),
        .res       (res.source)
    );

    adagrad_update_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .upd       (upd),
        .res       (res),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #3000000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic write_reg(cfg_index_t idx, logic [DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic drain();
        wait (pending == 0);
        repeat (45) @(posedge clk);
    endtask

    // Offers one transaction and returns after it has been accepted; valid stays high.
    task automatic send_update(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] g,
                               logic [DATA_W-1:0] p, logic restart);
        logic taken;
        upd.valid         <= 1'b1;
        upd.element_index <= idx;
        upd.gradient      <= g;
        upd.param_value   <= p;
        upd.restart       <= restart;
        do
        begin
            @(negedge clk);
            taken = upd.ready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic idle_sender(int cycles);
        upd.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic send_random(int count);
        logic [DATA_W-1:0] g;
        logic [IDX_W-1:0]  idx;
        int                burst;
        burst = $urandom_range(1, 24);
        for (int n = 0; n < count; n++)
        begin
            g = $urandom >> $urandom_range(0, 31);
            if ($urandom_range(0, 1))
                g = -g;
            if ($urandom_range(0, 40) == 0)
                g = 32'h8000_0000;
            idx = ($urandom_range(0, 9) < 6) ? IDX_W'($urandom_range(0, 31)) : IDX_W'($urandom);
            send_update(idx, g, $urandom, $urandom_range(0, 9) == 0);
            burst--;
            if (burst == 0)
            begin
                if ($urandom_range(0, 3) != 0)
                    idle_sender($urandom_range(1, 6));
                burst = $urandom_range(1, 24);
            end
        end
        upd.valid <= 1'b0;
    endtask

    // Result side: stretches of random stall patterns, plus one long hold on request.
    initial
    begin
        int mode;
        int len;
        res.ready = 1'b0;
        forever
        begin
            if (long_hold_go)
            begin
                res.ready <= 1'b0;
                repeat (300) @(posedge clk);
                long_hold_go = 1'b0;
            end
            mode = $urandom_range(0, 2);
            len  = $urandom_range(1, 40);
            repeat (len)
            begin
                @(posedge clk);
                case (mode)
                    0: res.ready <= 1'b1;
                    1: res.ready <= $urandom_range(0, 1);
                    default: res.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_LEARNING_RATE;
        cfg_wdata         = '0;
        long_hold_go      = 1'b0;
        upd.valid         = 1'b0;
        upd.element_index = '0;
        upd.gradient      = '0;
        upd.param_value   = '0;
        upd.restart       = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send_update(12'd0, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_update(12'd4095, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
        send_update(12'd4095, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_update(12'd1, 32'hffff_ffff, 32'h8000_0000, 1'b0);
        send_update(12'd1, 32'h0000_0001, 32'h7fff_ffff, 1'b1);
        send_update(12'd2, 32'h0001_0000, 32'h0000_0000, 1'b1);
        send_update(12'd2, 32'hffff_0000, 32'hffff_ffff, 1'b0);
        for (int i = 0; i < 6; i++)
            send_update(12'd7, 32'h8000_0000, 32'h1234_5678, 1'b0);
        send_update(12'd7, 32'h0000_0010, 32'h0000_0000, 1'b0);
        send_update(12'd7, 32'h8000_0000, 32'h0000_0000, 1'b1);
        send_update(12'd2048, 32'h5555_5555, 32'haaaa_aaaa, 1'b0);
        send_update(12'd2047, 32'haaaa_aaaa, 32'h5555_5555, 1'b0);
        upd.valid <= 1'b0;
        drain();

        write_reg(CFG_LEARNING_RATE, 32'hffff_ffff);
        write_reg(CFG_STABILIZER, 32'd1);
        send_update(12'd9, 32'h0000_0001, 32'h0000_0000, 1'b1);
        send_update(12'd9, 32'hffff_ffff, 32'h7fff_0000, 1'b1);
        send_update(12'd10, 32'h7fff_ffff, 32'h8000_0001, 1'b0);
        send_random(350);
        drain();

        write_reg(CFG_LEARNING_RATE, 32'd0);
        write_reg(CFG_STABILIZER, 32'd65535);
        send_random(150);
        long_hold_go = 1'b1;
        send_random(200);
        drain();

        write_reg(CFG_LEARNING_RATE, 32'hffff_ffff);
        write_reg(CFG_STABILIZER, 32'd0);
        send_update(12'd11, 32'h0000_0000, 32'h0000_0100, 1'b1);
        send_update(12'd11, 32'h0000_0000, 32'h8000_0000, 1'b0);
        send_random(170);
        wait (pending == 0);
        send_random(170);
        drain();

        write_reg(CFG_LEARNING_RATE, 32'h0001_0000);
        write_reg(CFG_STABILIZER, 32'h0000_8000);
        send_random(350);
        drain();

        write_reg(CFG_LEARNING_RATE, $urandom);
        write_reg(CFG_STABILIZER, $urandom_range(1, 65535));
        send_random(380);

        wait (pending == 0);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
